@@ hw/rtl/jsu_pkg.sv @@
// Shared types and codes for the JSON string unescape block.
`default_nettype none
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd2;
  localparam logic [2:0] ERR_ESC_CUT   = 3'd3;
  localparam logic [2:0] ERR_HEX_CUT   = 3'd4;
  localparam logic [2:0] ERR_CONTROL   = 3'd5;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd6;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd7;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Maximum data bytes one input byte can cause
  localparam int MAXB = 6;

  // One decoded request: data bytes, then an optional close or error result
  typedef struct packed {
    logic [MAXB-1:0][7:0] bytes;
    logic [2:0]           nbytes;
    logic                 term_en;
    logic [1:0]           term_kind;
    logic [2:0]           term_err;
  } jsu_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/jsu_front.sv @@
// Front part: parses the string byte by byte and builds at most one request per accepted byte.
`default_nettype none
module jsu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end_of_text,
  input  wire logic             q_full,
  output logic                  in_stall,
  output logic                  push,
  output jsu_pkg::jsu_cmd_t     cmd
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  // Encode a code point as one to four UTF-8 bytes, first byte at index 0
  function automatic utf8_t enc(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
      r.len = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len = 3'd2;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len = 3'd4;
    end
    return r;
  endfunction

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;

  logic        accept;
  logic        eot;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] cp_full;
  logic        flush_req, flush;
  logic        main_en, main_raw;
  logic [20:0] main_cp;
  logic        fail_en;
  logic [2:0]  fail_code;
  logic        close_en;
  utf8_t       flush_enc, main_enc;
  logic [3:0][7:0] main_bytes;
  logic [2:0]  main_len;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign eot      = in_end_of_text;

  // Classify a hex digit
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_d = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_d = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_full = {acc_r, hex_d};

  // Parse step: next state and what this byte produces
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    flush_req      = 1'b0;
    main_en        = 1'b0;
    main_raw       = 1'b0;
    main_cp        = '0;
    fail_en        = 1'b0;
    fail_code      = ERR_NONE;
    close_en       = 1'b0;
    unique case (phase_r)
      PH_BODY: begin
        if (eot) begin
          fail_en = 1'b1; fail_code = ERR_UNCLOSED;
        end else if (in_byte == 8'h5C) begin
          phase_nxt = PH_ESC;
        end else begin
          flush_req = 1'b1;
          if (in_byte == 8'h22) begin
            close_en  = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (in_byte < 8'h20) begin
            fail_en = 1'b1; fail_code = ERR_CONTROL;
          end else begin
            main_en  = 1'b1;
            main_raw = 1'b1;
          end
        end
      end
      PH_ESC: begin
        if (eot) begin
          fail_en = 1'b1; fail_code = ERR_ESC_CUT;
        end else if (in_byte == 8'h75) begin
          phase_nxt = PH_HEX;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end else begin
          flush_req = 1'b1;
          phase_nxt = PH_BODY;
          main_en   = 1'b1;
          unique case (in_byte)
            8'h22, 8'h5C, 8'h2F: main_cp = {13'd0, in_byte};
            8'h62:               main_cp = 21'h08;
            8'h66:               main_cp = 21'h0C;
            8'h6E:               main_cp = 21'h0A;
            8'h72:               main_cp = 21'h0D;
            8'h74:               main_cp = 21'h09;
            default: begin
              main_en = 1'b0;
              fail_en = 1'b1; fail_code = ERR_BAD_ESC;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (eot) begin
          fail_en = 1'b1; fail_code = ERR_HEX_CUT;
        end else if (!hex_ok) begin
          fail_en = 1'b1; fail_code = ERR_BAD_HEX;
        end else if (cnt_r == 2'd3) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          phase_nxt = PH_BODY;
          if (held_valid_r && cp_full[15:10] == 6'b110111) begin
            // join the pair into one supplementary code point
            main_en        = 1'b1;
            main_cp        = 21'h10000 + {1'b0, held_r, cp_full[9:0]};
            held_valid_nxt = 1'b0;
            held_nxt       = '0;
          end else begin
            flush_req      = 1'b1;
            held_valid_nxt = 1'b0;
            held_nxt       = '0;
            if (cp_full[15:10] == 6'b110110) begin
              held_nxt       = cp_full[9:0];
              held_valid_nxt = 1'b1;
            end else begin
              main_en = 1'b1;
              main_cp = {5'd0, cp_full};
            end
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          acc_nxt = {acc_r[7:0], hex_d};
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (!eot && in_byte == 8'h22) begin
          phase_nxt      = PH_BODY;
          cnt_nxt        = '0;
          acc_nxt        = '0;
          held_valid_nxt = 1'b0;
          held_nxt       = '0;
        end else begin
          fail_en = 1'b1; fail_code = ERR_NO_QUOTE;
        end
      end
    endcase
    // any error flushes the held surrogate and returns to idle
    if (fail_en) begin
      flush_req = 1'b1;
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      acc_nxt   = '0;
    end
    if (flush_req && !(phase_r == PH_HEX && !fail_en)) begin
      held_valid_nxt = 1'b0;
      held_nxt       = '0;
    end
  end

  assign flush     = flush_req && held_valid_r;
  assign flush_enc = enc({5'd0, 6'b110110, held_r});
  assign main_enc  = enc(main_cp);

  // Pick raw pass-through or encoded bytes
  always_comb begin
    if (main_raw) begin
      main_bytes    = '0;
      main_bytes[0] = in_byte;
      main_len      = 3'd1;
    end else begin
      main_bytes = main_enc.bytes;
      main_len   = main_enc.len;
    end
  end

  // Assemble the request: held bytes first, then this byte's output
  always_comb begin
    cmd.bytes     = '0;
    cmd.nbytes    = '0;
    cmd.term_en   = fail_en || close_en;
    cmd.term_kind = fail_en ? KIND_ERR : KIND_CLOSE;
    cmd.term_err  = fail_code;
    if (flush) begin
      cmd.bytes[0] = flush_enc.bytes[0];
      cmd.bytes[1] = flush_enc.bytes[1];
      cmd.bytes[2] = flush_enc.bytes[2];
      if (main_en) begin
        cmd.bytes[3] = main_bytes[0];
        cmd.bytes[4] = main_bytes[1];
        cmd.bytes[5] = main_bytes[2];
        cmd.nbytes   = 3'd3 + main_len;
      end else begin
        cmd.nbytes = 3'd3;
      end
    end else if (main_en) begin
      cmd.bytes[0] = main_bytes[0];
      cmd.bytes[1] = main_bytes[1];
      cmd.bytes[2] = main_bytes[2];
      cmd.bytes[3] = main_bytes[3];
      cmd.nbytes   = main_len;
    end
  end

  assign push = accept && (flush || main_en || fail_en || close_en);

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cnt_r        <= '0;
      acc_r        <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      acc_r        <= acc_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/jsu_fifo.sv @@
// Short request queue between the parsing front and the output back.
`default_nettype none
module jsu_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire jsu_pkg::jsu_cmd_t wdata,
  input  wire logic              pop,
  output jsu_pkg::jsu_cmd_t      head,
  output logic                   full,
  output logic                   empty
);
  import jsu_pkg::*;

  jsu_cmd_t       mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rptr_r];

  // Store a pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/jsu_back.sv @@
// Back part: walks each queued request and sends its results one per cycle while the output is not stalled.
`default_nettype none
module jsu_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jsu_pkg::jsu_cmd_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic [1:0]             out_kind,
  output logic [2:0]             out_error_code,
  output logic                   out_last
);
  import jsu_pkg::*;

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] err_r, err_nxt;
  logic       last_r, last_nxt;
  logic       move;
  logic [2:0] total;

  assign total = head.nbytes + {2'd0, head.term_en};
  assign move  = !empty && (!valid_r || !out_stall);
  assign pop   = move && last_nxt;

  // Select the result at the current position
  always_comb begin
    last_nxt = (idx_r == total - 3'd1);
    if (idx_r < head.nbytes) begin
      byte_nxt = head.bytes[idx_r];
      kind_nxt = KIND_DATA;
      err_nxt  = ERR_NONE;
    end else begin
      byte_nxt = 8'd0;
      kind_nxt = head.term_kind;
      err_nxt  = (head.term_kind == KIND_ERR) ? head.term_err : ERR_NONE;
    end
  end

  // Load the output register and step through the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (move) begin
        valid_r <= 1'b1;
        idx_r   <= last_nxt ? 3'd0 : idx_r + 3'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (move) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      err_r  <= err_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

@@ hw/rtl/json_string_unescape_utf8_top.sv @@
// Top level of the streaming JSON string unescaper with UTF-8 output.
// Takes one text byte per cycle unless the request queue is full, and emits
// one result per cycle unless the output is stalled. A byte that causes at
// most one result (plain characters and the closing quote with no high
// surrogate held, errors with nothing held, hex digits before the fourth)
// sustains one byte per cycle while the output is not stalled. A byte that
// completes an escape, or that follows a held high surrogate, can yield up to
// six results, which leave through a single output register. A four-entry
// request queue between the parser and the output absorbs these bursts, so
// the input stalls only when the queue fills. Bytes that cause no result
// (opening quote, backslash, hex digits before the fourth, a fourth digit
// that completes a high surrogate with none held) enter and leave the parser
// without using the queue, and the results of other bytes pass through it.
`default_nettype none
module json_string_unescape_utf8_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic [2:0]      out_error_code,
  output logic            out_last
);
  import jsu_pkg::*;

  jsu_cmd_t push_cmd, head_cmd;
  logic     push, pop, q_full, q_empty;

  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .cmd            (push_cmd)
  );

  jsu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .head  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head_cmd),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

@@ hw/rtl/jsu_checker.sv @@
// Port-level checks for the JSON string unescaper, bound to the top level.
`default_nettype none
module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] out_kind,
  input wire logic [2:0] out_error_code,
  input wire logic       out_last
);
  import jsu_pkg::*;

  // Close and error always end the results of a request
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CLOSE || out_kind == KIND_ERR) |-> out_last)
    else $error("close or error result without last");

  // Only error results carry an error code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERR |-> out_error_code == ERR_NONE)
    else $error("error code on non-error result");

  // Non-data results carry a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("byte on non-data result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_kind       (out_kind),
  .out_error_code (out_error_code),
  .out_last       (out_last)
);
`default_nettype wire

@@ tb/json_string_unescape_utf8_top_test.sv @@
// Self-checking bench for the JSON string unescaper with UTF-8 output.
module json_string_unescape_utf8_top_test;
  import jsu_pkg::*;

  // Characters the decoder reacts to
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
  localparam logic [15:0] SURR_HIGH_HI = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;

  localparam int QUIET_LIMIT = 1000;
  localparam int REPORT_MAX  = 40;

  typedef enum logic [2:0] {ST_IDLE = 3'd0, ST_BODY = 3'd1, ST_ESC = 3'd2, ST_HEX = 3'd3}
    scan_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  // Decoder state mirrored by the bench
  scan_state_t scan_st;
  logic [2:0]  digits_taken;
  logic [15:0] hex_acc;
  logic [9:0]  held_bits;
  logic        high_held;

  result_t    due_results[$];
  result_t    step_out[$];
  text_item_t text_q[$];
  result_t    want;

  int in_idle_pct;
  int out_stall_pct;
  int items_sent;
  int mismatch_count;
  int quiet_cycles;

  json_string_unescape_utf8_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Expected-result computation
  // ---------------------------------------------------------------------------

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);        // 0-9
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;   // a-f
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;   // A-F
    return -1;
  endfunction

  task automatic put_result(input logic [7:0] d, input logic [1:0] k, input logic [2:0] e);
    result_t r;
    r.data = d;
    r.kind = k;
    r.err  = e;
    r.last = 1'b0;
    step_out = {step_out, r};
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_result(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp < 21'h800) begin
      put_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      put_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp < 21'h10000) begin
      put_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      put_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      put_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      put_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      put_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      put_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      put_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endtask

  // Send a held high surrogate on its own as three bytes
  task automatic release_high();
    if (high_held) begin
      put_utf8({5'd0, 6'b110110, held_bits});
      high_held = 1'b0;
      held_bits = '0;
    end
  endtask

  task automatic raise_error(input logic [2:0] code);
    release_high();
    put_result(8'h00, KIND_ERR, code);
    scan_st      = ST_IDLE;
    digits_taken = '0;
    hex_acc      = '0;
  endtask

  // Pair with a held high surrogate, hold a new one, or emit the code point
  task automatic finish_code(input logic [15:0] cp);
    if (high_held && cp >= SURR_LOW_LO && cp <= SURR_LOW_HI) begin
      put_utf8(21'h10000 + {1'b0, held_bits, cp[9:0]});
      high_held = 1'b0;
      held_bits = '0;
    end else begin
      release_high();
      if (cp >= SURR_HIGH_LO && cp <= SURR_HIGH_HI) begin
        held_bits = cp[9:0];
        high_held = 1'b1;
      end else begin
        put_utf8({5'd0, cp});
      end
    end
  endtask

  task automatic decode_text_byte(input logic [7:0] b, input logic eot);
    int          nib;
    logic [15:0] cp;
    result_t     tail_r;
    step_out.delete();
    case (scan_st)
      ST_BODY: begin
        if (eot) begin
          raise_error(ERR_UNCLOSED);
        end else if (b == CH_BSLASH) begin
          scan_st = ST_ESC;
        end else begin
          release_high();
          if (b == CH_QUOTE) begin
            put_result(8'h00, KIND_CLOSE, ERR_NONE);
            scan_st = ST_IDLE;
          end else if (b < CH_SPACE) begin
            raise_error(ERR_CONTROL);
          end else begin
            put_result(b, KIND_DATA, ERR_NONE);
          end
        end
      end
      ST_ESC: begin
        if (eot) begin
          raise_error(ERR_ESC_CUT);
        end else if (b == CH_U) begin
          scan_st      = ST_HEX;
          digits_taken = '0;
          hex_acc      = '0;
        end else begin
          release_high();
          scan_st = ST_BODY;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: put_result(b, KIND_DATA, ERR_NONE);
            CH_B: put_result(8'h08, KIND_DATA, ERR_NONE);
            CH_F: put_result(8'h0C, KIND_DATA, ERR_NONE);
            CH_N: put_result(8'h0A, KIND_DATA, ERR_NONE);
            CH_R: put_result(8'h0D, KIND_DATA, ERR_NONE);
            CH_T: put_result(8'h09, KIND_DATA, ERR_NONE);
            default: raise_error(ERR_BAD_ESC);
          endcase
        end
      end
      ST_HEX: begin
        if (eot) begin
          raise_error(ERR_HEX_CUT);
        end else begin
          nib = hex_nibble(b);
          if (nib < 0) begin
            raise_error(ERR_BAD_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (digits_taken >= 3'd3) begin
              cp           = hex_acc;
              digits_taken = '0;
              hex_acc      = '0;
              scan_st      = ST_BODY;
              finish_code(cp);
            end else begin
              digits_taken = digits_taken + 3'd1;
            end
          end
        end
      end
      default: begin
        scan_st = ST_IDLE;
        if (!eot && b == CH_QUOTE) begin
          scan_st      = ST_BODY;
          digits_taken = '0;
          hex_acc      = '0;
          high_held    = 1'b0;
          held_bits    = '0;
        end else begin
          raise_error(ERR_NO_QUOTE);
        end
      end
    endcase
    // Mark the final result of this byte, then queue them all
    if (step_out.size() > 0) begin
      tail_r = step_out.pop_back();
      tail_r.last = 1'b1;
      step_out = {step_out, tail_r};
    end
    due_results = {due_results, step_out};
  endtask

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  // Drive one request, idling first at random, and hold it until accepted
  task automatic send_text_item(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_text_byte(b, eot);
    items_sent++;
  endtask

  task automatic send_queue();
    text_item_t it;
    while (text_q.size() > 0) begin
      it = text_q.pop_front();
      send_text_item(it.b, it.eot);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Text building
  // ---------------------------------------------------------------------------

  task automatic add_item(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.b   = b;
    it.eot = eot;
    text_q = {text_q, it};
  endtask

  // End of text carries a random byte that must be ignored
  task automatic add_eot();
    add_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + (n - 4'd10);
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape_letter(input int idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // Boundaries of the UTF-8 length classes and of the surrogate ranges
  function automatic logic [15:0] corner_code(input int idx);
    case (idx)
      0: return 16'h0000;
      1: return 16'h007F;
      2: return 16'h0080;
      3: return 16'h07FF;
      4: return 16'h0800;
      5: return 16'hFFFF;
      6: return SURR_HIGH_LO;
      7: return SURR_HIGH_HI;
      8: return SURR_LOW_LO;
      default: return SURR_LOW_HI;
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 32)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] bad_escape_letter();
    logic [7:0] c;
    do c = 8'($urandom); while (is_escape_letter(c));
    return c;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = 8'($urandom); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  // Backslash-u followed by the first ndigits hex digits of cp
  task automatic add_hex_escape(input logic [15:0] cp, input int ndigits);
    add_item(CH_BSLASH, 1'b0);
    add_item(CH_U, 1'b0);
    for (int i = 0; i < ndigits; i++) add_item(hex_char(cp[15 - 4*i -: 4]), 1'b0);
  endtask

  task automatic add_element();
    case ($urandom_range(9))
      0, 1, 2: add_item(plain_char(), 1'b0);
      3: begin
        add_item(CH_BSLASH, 1'b0);
        add_item(simple_escape_letter($urandom_range(7)), 1'b0);
      end
      4: add_hex_escape(16'($urandom_range(16'h07FF)), 4);
      5: add_hex_escape(16'($urandom_range(16'hFFFF)), 4);
      6, 7: begin
        add_hex_escape(16'($urandom_range(SURR_HIGH_HI, SURR_HIGH_LO)), 4);
        add_hex_escape(16'($urandom_range(SURR_LOW_HI, SURR_LOW_LO)), 4);
      end
      8: add_hex_escape(16'($urandom_range(SURR_LOW_HI, SURR_HIGH_LO)), 4);
      default: add_hex_escape(corner_code($urandom_range(9)), 4);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A non-quote byte and then end of text while idle are both refused
  task automatic test_no_quote();
    add_item(8'h78, 1'b0);
    add_eot();
    send_queue();
  endtask

  // DEL, top byte and space pass through unchanged
  task automatic test_plain_bytes();
    add_item(CH_QUOTE, 1'b0);
    add_item(8'h7F, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(CH_SPACE, 1'b0);
    add_item(CH_QUOTE, 1'b0);
    send_queue();
  endtask

  // Held high surrogate flushed ahead of a 3-byte code point (six results),
  // then held again and flushed ahead of an unclosed-string error
  task automatic test_surrogate_flush();
    add_item(CH_QUOTE, 1'b0);
    add_hex_escape(SURR_HIGH_HI, 4);
    add_hex_escape(16'hFFFF, 4);
    add_hex_escape(SURR_HIGH_LO, 4);
    add_eot();
    send_queue();
  endtask

  task automatic test_valid_strings(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      add_item(CH_QUOTE, 1'b0);
      repeat ($urandom_range(6)) add_element();
      add_item(CH_QUOTE, 1'b0);
      send_queue();
    end
  endtask

  // Strings that break off with each error but a missing opening quote, often with a surrogate held
  task automatic test_broken_strings(input int budget);
    int         start;
    logic [2:0] fault;
    start = items_sent;
    while (items_sent - start < budget) begin
      add_item(CH_QUOTE, 1'b0);
      repeat ($urandom_range(2)) add_element();
      if ($urandom_range(1))
        add_hex_escape(16'($urandom_range(SURR_HIGH_HI, SURR_HIGH_LO)), 4);
      fault = 3'($urandom_range(ERR_BAD_HEX, ERR_UNCLOSED));
      case (fault)
        ERR_UNCLOSED: add_eot();
        ERR_CONTROL:  add_item(8'($urandom_range(31)), 1'b0);
        ERR_ESC_CUT: begin
          add_item(CH_BSLASH, 1'b0);
          add_eot();
        end
        ERR_BAD_ESC: begin
          add_item(CH_BSLASH, 1'b0);
          add_item(bad_escape_letter(), 1'b0);
        end
        ERR_HEX_CUT: begin
          add_hex_escape(16'($urandom), $urandom_range(3));
          add_eot();
        end
        default: begin
          add_hex_escape(16'($urandom), $urandom_range(3));
          add_item(bad_hex_char(), 1'b0);
        end
      endcase
      send_queue();
    end
  endtask

  // Random bytes weighted toward the special characters; end of text
  // closes each burst so the decoder is idle again
  task automatic test_noise(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      repeat ($urandom_range(12, 4)) begin
        case ($urandom_range(7))
          0: add_eot();
          1: add_item(CH_QUOTE, 1'b0);
          2: add_item(CH_BSLASH, 1'b0);
          3: add_item(hex_char(4'($urandom_range(15))), 1'b0);
          default: add_item(8'($urandom), 1'b0);
        endcase
      end
      add_eot();
      send_queue();
    end
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    test_valid_strings(40);
    test_broken_strings(22);
    test_noise(8);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each accepted result against the oldest due result
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d err %0d last %0d",
                                  out_byte, out_kind, out_error_code, out_last));
      end else begin
        want = due_results.pop_front();
        if (out_byte !== want.data || out_kind !== want.kind ||
            out_error_code !== want.err || out_last !== want.last)
          report_mismatch($sformatf(
            "result byte %02h kind %0d err %0d last %0d, due %02h kind %0d err %0d last %0d",
            out_byte, out_kind, out_error_code, out_last,
            want.data, want.kind, want.err, want.last));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("json_string_unescape_utf8_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    out_stall      = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    items_sent     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    scan_st        = ST_IDLE;
    digits_taken   = '0;
    hex_acc        = '0;
    held_bits      = '0;
    high_held      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_no_quote();
    test_plain_bytes();
    test_surrogate_flush();

    run_random_phase(0, 0);
    run_random_phase(71, 0);
    run_random_phase(0, 71);
    run_random_phase(36, 36);

    // Drain, then keep watching for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    if (mismatch_count == 0) $display("json_string_unescape_utf8_top: match");
    else $display("json_string_unescape_utf8_top: mismatch");
    $finish;
  end

endmodule
